[rtl/hbca_pkg.sv]
// ----------------------------------------------------------------------------
// hbca_pkg
// Shared constants for the half-block cell averager: field widths, register
// indexes, reset values and default size limits.
// ----------------------------------------------------------------------------
package hbca_pkg;

  localparam int DATA_W = 8;   // color component
  localparam int CFG_W  = 13;  // widest configuration register
  localparam int IDX_W  = 3;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_BLOCK_WIDTH  = 3'd2;
  localparam logic [IDX_W-1:0] REG_BLOCK_HEIGHT = 3'd3;
  localparam logic [IDX_W-1:0] REG_CELLS_ACROSS = 3'd4;
  localparam logic [IDX_W-1:0] REG_CELLS_DOWN   = 3'd5;
  localparam logic [IDX_W-1:0] REG_HALF_MODE    = 3'd6;

  // register field widths
  localparam int FW_RAW_W = 13;
  localparam int FH_RAW_W = 13;
  localparam int BW_RAW_W = 7;
  localparam int BH_RAW_W = 7;
  localparam int CA_RAW_W = 9;
  localparam int CD_RAW_W = 12;

  // reset values
  localparam logic [FW_RAW_W-1:0] RST_FRAME_WIDTH  = 13'd640;
  localparam logic [FH_RAW_W-1:0] RST_FRAME_HEIGHT = 13'd480;
  localparam logic [BW_RAW_W-1:0] RST_BLOCK_WIDTH  = 7'd8;
  localparam logic [BH_RAW_W-1:0] RST_BLOCK_HEIGHT = 7'd8;
  localparam logic [CA_RAW_W-1:0] RST_CELLS_ACROSS = 9'd80;
  localparam logic [CD_RAW_W-1:0] RST_CELLS_DOWN   = 12'd30;
  localparam logic                RST_HALF_MODE    = 1'b1;

  // default limits
  localparam int DEF_MAX_CELLS_ACROSS = 256;
  localparam int DEF_MAX_BLOCK_WIDTH  = 64;
  localparam int DEF_MAX_BLOCK_HEIGHT = 64;
  localparam int DEF_MAX_FRAME_DIM    = 4096;

endpackage

[rtl/hbca_pixel_if.sv]
// ----------------------------------------------------------------------------
// hbca_pixel_if
// Valid/ready channel carrying one RGB pixel per transfer.
// ----------------------------------------------------------------------------
interface hbca_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [hbca_pkg::DATA_W-1:0] red;
  logic [hbca_pkg::DATA_W-1:0] green;
  logic [hbca_pkg::DATA_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

[rtl/hbca_cell_if.sv]
// ----------------------------------------------------------------------------
// hbca_cell_if
// Valid/ready channel carrying one averaged cell per transfer.
// ----------------------------------------------------------------------------
interface hbca_cell_if;
  logic                        valid;
  logic                        ready;
  logic [hbca_pkg::DATA_W-1:0] fg_red;
  logic [hbca_pkg::DATA_W-1:0] fg_green;
  logic [hbca_pkg::DATA_W-1:0] fg_blue;
  logic [hbca_pkg::DATA_W-1:0] bg_red;
  logic [hbca_pkg::DATA_W-1:0] bg_green;
  logic [hbca_pkg::DATA_W-1:0] bg_blue;
  logic                        row_end;
  logic                        frame_end;

  modport source (output valid, fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue,
                  row_end, frame_end, input ready);
  modport sink   (input valid, fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue,
                  row_end, frame_end, output ready);
endinterface

[rtl/hbca_div.sv]
// ----------------------------------------------------------------------------
// hbca_div
// Restoring divider, one quotient bit per cycle. The quotient must fit in
// QW bits. busy is high from start until the last quotient bit is in.
// ----------------------------------------------------------------------------
module hbca_div #(
  parameter int NW = 20,
  parameter int DW = 13,
  parameter int QW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [QW-1:0] quo,
  output logic [DW-1:0] rem
);

  localparam int CNT_W = $clog2(QW + 1);

  logic [CNT_W-1:0] cnt;
  logic [DW:0]      trial;
  logic             ge;

  assign trial = {rem, quo[QW-1]};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(QW);
    end else if (busy) begin
      busy <= (cnt != CNT_W'(1));
      cnt  <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= DW'(num >> QW);
      quo <= num[QW-1:0];
    end else if (busy) begin
      rem <= ge ? DW'(trial - {1'b0, den}) : DW'(trial);
      quo <= {quo[QW-2:0], ge};
    end
  end

endmodule

[rtl/half_block_cell_averager.sv]
// ----------------------------------------------------------------------------
// half_block_cell_averager
// Block-average downscaler: RGB raster pixels in, one averaged cell out.
// ----------------------------------------------------------------------------
// Usage:
//  - pix (sink) takes one pixel per transfer, raster order. tile (source)
//    gives one transfer per completed cell: fg/bg colors plus row_end and
//    frame_end flags. Pixels outside the cell grid give no transfer.
//  - cfg_we/cfg_index/cfg_data write the size and mode registers; write
//    only while the block is idle. Any write triggers a position resync
//    (two XW-bit dividers, XW = log2 of MAX_FRAME_DIM) before the next
//    pixel is taken; a write that lands during a resync starts another.
//  - Pixels are not overlapped: each one passes accept, sum read, and
//    update and write back before the next is taken; the sum memory's
//    read-modify-write sets this. A pixel that closes a cell then runs
//    the divide (one quotient bit per cycle), leaves the divide state and
//    loads the output register, once free, which raises tile.valid.
//  - Output stall: the finished cell sits in the output register; the
//    next pixels are still taken, and only a second finished cell waits.
//  - Reset: registers go to their defaults, position to the top-left
//    corner, all column sums read as zero (valid bit per column).
// ----------------------------------------------------------------------------
module half_block_cell_averager #(
  parameter int MAX_CELLS_ACROSS = hbca_pkg::DEF_MAX_CELLS_ACROSS,
  parameter int MAX_BLOCK_WIDTH  = hbca_pkg::DEF_MAX_BLOCK_WIDTH,
  parameter int MAX_BLOCK_HEIGHT = hbca_pkg::DEF_MAX_BLOCK_HEIGHT,
  parameter int MAX_FRAME_DIM    = hbca_pkg::DEF_MAX_FRAME_DIM
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [hbca_pkg::IDX_W-1:0]  cfg_index,
  input  logic [hbca_pkg::CFG_W-1:0]  cfg_data,
  hbca_pixel_if.sink                  pix,
  hbca_cell_if.source                 tile
);

  localparam int DW    = hbca_pkg::DATA_W;
  localparam int XW    = $clog2(MAX_FRAME_DIM);          // pixel position
  localparam int FW_W  = $clog2(MAX_FRAME_DIM + 1);      // frame size value
  localparam int BW_W  = $clog2(MAX_BLOCK_WIDTH + 1);
  localparam int BH_W  = $clog2(MAX_BLOCK_HEIGHT + 1);
  localparam int BH2_W = BH_W + 1;                       // 2 * block height
  localparam int RY_W  = $clog2(2 * MAX_BLOCK_HEIGHT);
  localparam int CA_W  = $clog2(MAX_CELLS_ACROSS + 1);
  localparam int AW    = (MAX_CELLS_ACROSS > 1) ? $clog2(MAX_CELLS_ACROSS) : 1;
  localparam int CT_W  = $clog2(MAX_BLOCK_WIDTH * MAX_BLOCK_HEIGHT + 1);
  localparam int SUM_W = $clog2(MAX_BLOCK_WIDTH * MAX_BLOCK_HEIGHT * 255 + 1);
  localparam int NSUM  = 6;

  // state codes
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_READ    = 3'd1;
  localparam logic [2:0] S_UPDATE  = 3'd2;
  localparam logic [2:0] S_DIV     = 3'd3;
  localparam logic [2:0] S_DONE    = 3'd4;
  localparam logic [2:0] S_SYNC_GO = 3'd5;
  localparam logic [2:0] S_SYNC    = 3'd6;

  // ---------------- configuration registers ----------------
  logic [hbca_pkg::FW_RAW_W-1:0] r_fw;
  logic [hbca_pkg::FH_RAW_W-1:0] r_fh;
  logic [hbca_pkg::BW_RAW_W-1:0] r_bw;
  logic [hbca_pkg::BH_RAW_W-1:0] r_bh;
  logic [hbca_pkg::CA_RAW_W-1:0] r_ca;
  logic [hbca_pkg::CD_RAW_W-1:0] r_cd;
  logic                          r_half;
  logic                          resync;

  logic [2:0] state;

  // resync request is taken when the dividers launch; a later write re-arms it
  always_ff @(posedge clk) begin
    if (rst) begin
      r_fw   <= hbca_pkg::RST_FRAME_WIDTH;
      r_fh   <= hbca_pkg::RST_FRAME_HEIGHT;
      r_bw   <= hbca_pkg::RST_BLOCK_WIDTH;
      r_bh   <= hbca_pkg::RST_BLOCK_HEIGHT;
      r_ca   <= hbca_pkg::RST_CELLS_ACROSS;
      r_cd   <= hbca_pkg::RST_CELLS_DOWN;
      r_half <= hbca_pkg::RST_HALF_MODE;
      resync <= 1'b0;
    end else begin
      if (state == S_SYNC_GO) resync <= 1'b0;
      if (cfg_we) begin
        resync <= 1'b1;
        case (cfg_index)
          hbca_pkg::REG_FRAME_WIDTH:  r_fw   <= cfg_data[hbca_pkg::FW_RAW_W-1:0];
          hbca_pkg::REG_FRAME_HEIGHT: r_fh   <= cfg_data[hbca_pkg::FH_RAW_W-1:0];
          hbca_pkg::REG_BLOCK_WIDTH:  r_bw   <= cfg_data[hbca_pkg::BW_RAW_W-1:0];
          hbca_pkg::REG_BLOCK_HEIGHT: r_bh   <= cfg_data[hbca_pkg::BH_RAW_W-1:0];
          hbca_pkg::REG_CELLS_ACROSS: r_ca   <= cfg_data[hbca_pkg::CA_RAW_W-1:0];
          hbca_pkg::REG_CELLS_DOWN:   r_cd   <= cfg_data[hbca_pkg::CD_RAW_W-1:0];
          hbca_pkg::REG_HALF_MODE:    r_half <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // effective sizes: zero acts as one, clamp to the limits
  logic [FW_W-1:0]                 fw, fh;
  logic [BW_W-1:0]                 bw;
  logic [BH_W-1:0]                 bh;
  logic [BH2_W-1:0]                bh2;
  logic [CA_W-1:0]                 ca;
  logic [hbca_pkg::CD_RAW_W-1:0]   cd;

  always_comb begin
    if (r_fw == '0)                          fw = FW_W'(1);
    else if (32'(r_fw) > MAX_FRAME_DIM)      fw = FW_W'(MAX_FRAME_DIM);
    else                                     fw = FW_W'(r_fw);
    if (r_fh == '0)                          fh = FW_W'(1);
    else if (32'(r_fh) > MAX_FRAME_DIM)      fh = FW_W'(MAX_FRAME_DIM);
    else                                     fh = FW_W'(r_fh);
    if (r_bw == '0)                          bw = BW_W'(1);
    else if (32'(r_bw) > MAX_BLOCK_WIDTH)    bw = BW_W'(MAX_BLOCK_WIDTH);
    else                                     bw = BW_W'(r_bw);
    if (r_bh == '0)                          bh = BH_W'(1);
    else if (32'(r_bh) > MAX_BLOCK_HEIGHT)   bh = BH_W'(MAX_BLOCK_HEIGHT);
    else                                     bh = BH_W'(r_bh);
    if (r_ca == '0)                          ca = CA_W'(1);
    else if (32'(r_ca) > MAX_CELLS_ACROSS)   ca = CA_W'(MAX_CELLS_ACROSS);
    else                                     ca = CA_W'(r_ca);
    cd  = (r_cd == '0) ? hbca_pkg::CD_RAW_W'(1) : r_cd;
    bh2 = {bh, 1'b0};
  end

  // ---------------- position counters ----------------
  // x, y is the next pixel; cx/xm and cy/ry are its cell and offset
  logic [XW-1:0]   x, y, cx, cy;
  logic [BW_W-1:0] xm;
  logic [RY_W-1:0] ry;

  logic accept;
  assign pix.ready = (state == S_IDLE) && !resync;
  assign accept    = pix.valid && pix.ready;

  // resync dividers: x / bw and y / (2 * bh)
  logic            sync_start, sync_busy, ysync_busy;
  logic [XW-1:0]   sx_q, sy_q;
  logic [BW_W-1:0] sx_r;
  logic [BH2_W-1:0] sy_r;

  assign sync_start = (state == S_SYNC_GO);

  hbca_div #(.NW(XW), .DW(BW_W), .QW(XW)) u_xsync (
    .clk(clk), .rst(rst), .start(sync_start), .num(x), .den(bw),
    .busy(sync_busy), .quo(sx_q), .rem(sx_r)
  );

  hbca_div #(.NW(XW), .DW(BH2_W), .QW(XW)) u_ysync (
    .clk(clk), .rst(rst), .start(sync_start), .num(y), .den(bh2),
    .busy(ysync_busy), .quo(sy_q), .rem(sy_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      x  <= '0;
      y  <= '0;
      cx <= '0;
      cy <= '0;
      xm <= '0;
      ry <= '0;
    end else if (state == S_SYNC && !sync_busy) begin
      cx <= sx_q;
      xm <= sx_r;
      cy <= sy_q;
      ry <= RY_W'(sy_r);
    end else if (accept) begin
      if (32'(x) + 1 >= 32'(fw)) begin
        x  <= '0;
        cx <= '0;
        xm <= '0;
        if (32'(y) + 1 >= 32'(fh)) begin
          y  <= '0;
          cy <= '0;
          ry <= '0;
        end else begin
          y <= y + XW'(1);
          if (32'(ry) + 1 == 32'(bh2)) begin
            ry <= '0;
            cy <= cy + XW'(1);
          end else begin
            ry <= ry + RY_W'(1);
          end
        end
      end else begin
        x <= x + XW'(1);
        if (32'(xm) + 1 == 32'(bw)) begin
          xm <= '0;
          cx <= cx + XW'(1);
        end else begin
          xm <= xm + BW_W'(1);
        end
      end
    end
  end

  // ---------------- pixel capture ----------------
  logic [XW-1:0]   p_x, p_y, p_cx, p_cy;
  logic [BW_W-1:0] p_xm;
  logic [RY_W-1:0] p_ry;
  logic [DW-1:0]   p_pix [3];
  logic [AW-1:0]   p_addr;

  always_ff @(posedge clk) begin
    if (accept) begin
      p_x      <= x;
      p_y      <= y;
      p_cx     <= cx;
      p_cy     <= cy;
      p_xm     <= xm;
      p_ry     <= ry;
      p_addr   <= AW'(cx);
      p_pix[0] <= pix.red;
      p_pix[1] <= pix.green;
      p_pix[2] <= pix.blue;
    end
  end

  // ---------------- cell geometry (during the memory read) ----------------
  logic [XW-1:0]   x0, y0;
  logic [31:0]     fw_left, fh_left;
  logic [BW_W-1:0] wc;
  logic [BH_W-1:0] ht, hb;
  logic            geo_ok, geo_last, geo_re;

  always_comb begin
    x0      = p_x - XW'(p_xm);
    y0      = p_y - XW'(p_ry);
    fw_left = 32'(fw) - 32'(x0);
    fh_left = 32'(fh) - 32'(y0);
    wc      = (fw_left < 32'(bw)) ? BW_W'(fw_left) : bw;
    ht      = (fh_left < 32'(bh)) ? BH_W'(fh_left) : bh;
    if (fh_left > 32'(bh))
      hb = (fh_left - 32'(bh) < 32'(bh)) ? BH_W'(fh_left - 32'(bh)) : bh;
    else
      hb = '0;
    geo_ok   = (32'(p_x) < 32'(fw)) && (32'(p_y) < 32'(fh)) &&
               (32'(p_cx) < 32'(ca)) && (32'(p_cy) < 32'(cd));
    geo_last = (32'(p_xm) + 1 == 32'(wc)) && (32'(p_ry) + 1 == 32'(ht) + 32'(hb));
    geo_re   = (32'(p_cx) + 1 == 32'(ca));
  end

  logic            g_ok, g_start, g_upper, g_last, g_re, g_fe, g_cb_zero;
  logic [CT_W-1:0] g_ct, g_cb;

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      g_ok      <= geo_ok;
      g_start   <= (p_xm == '0) && (p_ry == '0);
      g_upper   <= 32'(p_ry) < 32'(bh);
      g_last    <= geo_last;
      g_re      <= geo_re;
      g_fe      <= geo_re && (32'(p_cy) + 1 == 32'(cd));
      g_ct      <= CT_W'(wc) * CT_W'(ht);
      g_cb      <= CT_W'(wc) * CT_W'(hb);
      g_cb_zero <= (hb == '0);
    end
  end

  // ---------------- column sum memory ----------------
  // six sums per cell column, packed in one word
  logic [NSUM*SUM_W-1:0]     mem [MAX_CELLS_ACROSS];
  logic [NSUM*SUM_W-1:0]     rd_data, wr_data;
  logic [MAX_CELLS_ACROSS-1:0] col_valid;
  logic [SUM_W-1:0]          sum_new [NSUM];
  logic                      mem_we;

  assign mem_we = (state == S_UPDATE) && g_ok;

  always_ff @(posedge clk) begin
    if (accept) rd_data <= mem[AW'(cx)];
    if (mem_we) mem[p_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) col_valid <= '0;
    else if (mem_we) col_valid[p_addr] <= 1'b1;
  end

  always_comb begin
    for (int k = 0; k < NSUM; k++) begin
      if (g_start || !col_valid[p_addr])
        sum_new[k] = '0;
      else
        sum_new[k] = rd_data[k*SUM_W +: SUM_W];
      if (g_upper && k < 3)
        sum_new[k] = sum_new[k] + SUM_W'(p_pix[k % 3]);
      else if (!g_upper && k >= 3)
        sum_new[k] = sum_new[k] + SUM_W'(p_pix[k % 3]);
      wr_data[k*SUM_W +: SUM_W] = sum_new[k];
    end
  end

  // ---------------- averaging dividers ----------------
  // upper sums by wc*ht, lower by wc*hb; quotients are at most 255
  logic          avg_start;
  logic [NSUM-1:0] avg_busy;
  logic [DW-1:0] avg_q [NSUM];
  logic [CT_W-1:0] avg_r [NSUM];

  assign avg_start = (state == S_UPDATE) && g_ok && g_last;

  for (genvar k = 0; k < NSUM; k++) begin : g_avg
    hbca_div #(.NW(SUM_W), .DW(CT_W), .QW(DW)) u_div (
      .clk(clk), .rst(rst), .start(avg_start), .num(sum_new[k]),
      .den((k < 3) ? g_ct : g_cb),
      .busy(avg_busy[k]), .quo(avg_q[k]), .rem(avg_r[k])
    );
  end

  // ---------------- result ----------------
  logic [DW-1:0] lo_avg [3];
  logic [DW:0]   comb_sum [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lo_avg[k]   = g_cb_zero ? '0 : avg_q[k+3];
      comb_sum[k] = {1'b0, avg_q[k]} + {1'b0, lo_avg[k]};
    end
  end

  logic out_load;
  assign out_load = (state == S_DONE) && (!tile.valid || tile.ready);

  always_ff @(posedge clk) begin
    if (rst) tile.valid <= 1'b0;
    else if (out_load) tile.valid <= 1'b1;
    else if (tile.ready) tile.valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      tile.fg_red    <= r_half ? avg_q[0] : comb_sum[0][DW:1];
      tile.fg_green  <= r_half ? avg_q[1] : comb_sum[1][DW:1];
      tile.fg_blue   <= r_half ? avg_q[2] : comb_sum[2][DW:1];
      tile.bg_red    <= r_half ? lo_avg[0] : '0;
      tile.bg_green  <= r_half ? lo_avg[1] : '0;
      tile.bg_blue   <= r_half ? lo_avg[2] : '0;
      tile.row_end   <= g_re;
      tile.frame_end <= g_fe;
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (resync) state <= S_SYNC_GO;
          else if (accept) state <= S_READ;
        end
        S_READ:    state <= S_UPDATE;
        S_UPDATE:  state <= avg_start ? S_DIV : S_IDLE;
        S_DIV:     if (!avg_busy[0]) state <= S_DONE;
        S_DONE:    if (out_load) state <= S_IDLE;
        S_SYNC_GO: state <= S_SYNC;
        S_SYNC:    if (!sync_busy) state <= S_IDLE;
        default:   state <= S_IDLE;
      endcase
    end
  end

  // ---------------- checks ----------------
  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_READ)
    else $error("accepted pixel did not start a sum read");

  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    avg_busy[0] |-> state == S_DIV)
    else $error("averaging divider busy outside divide state");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(tile.valid) |-> $past(state) == S_DONE)
    else $error("result shown without a finished cell");

  a_sync_pair: assert property (@(posedge clk) disable iff (rst)
    sync_busy == ysync_busy)
    else $error("position resync dividers out of step");

endmodule
